// ----- rtl/assert_macros.svh -----
// Assertion macros used by the output stage of the beacon receiver sector mask RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BRSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BRSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/brsm_pkg.sv -----
// Types, constants and the arctangent table of the beacon receiver sector mask.
`default_nettype none

package brsm_pkg;

  // Number of beacons that can be live; higher indexes read as absent.
  localparam int BEACON_COUNT  = 8;
  // Rotations of the arctangent pipeline; the table holds 19 entries.
  localparam int CORDIC_STAGES = 16;
  localparam int CELL_COUNT    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

  localparam int COORD_W = 14;
  localparam int DIFF_W  = 15;
  localparam int XY_W    = 26;
  localparam int ACC_W   = 20;
  localparam int SQ_W    = 28;
  localparam int STAGE_W = 5;

  // Angle accumulator value of a half turn (2^20 units per turn).
  localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(1 << (ACC_W - 1));

  // Register reset values: 80 degrees, 1.5 m, 1 m and 0.5 m.
  localparam logic [15:0] BEARING_OFFSET_RST = 16'd14564;
  localparam int RADIUS_WIDE_RST = 1500;
  localparam int RADIUS_MID_RST  = 1000;
  localparam int RADIUS_NEAR_RST = 500;
  localparam logic [SQ_W-1:0] RSQ_WIDE_RST = SQ_W'(RADIUS_WIDE_RST * RADIUS_WIDE_RST);
  localparam logic [SQ_W-1:0] RSQ_MID_RST  = SQ_W'(RADIUS_MID_RST * RADIUS_MID_RST);
  localparam logic [SQ_W-1:0] RSQ_NEAR_RST = SQ_W'(RADIUS_NEAR_RST * RADIUS_NEAR_RST);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BEARING_OFFSET = 2'd0,
    CFG_RADIUS_WIDE    = 2'd1,
    CFG_RADIUS_MID     = 2'd2,
    CFG_RADIUS_NEAR    = 2'd3
  } cfg_reg_t;

  // One request as it moves down the rotation chain.
  typedef struct packed {
    logic [2:0]             idx;
    logic                   active;
    logic                   zero;
    logic [15:0]            heading;
    logic [SQ_W-1:0]        sqx;
    logic [SQ_W-1:0]        sqz;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ACC_W-1:0]       acc;
  } brsm_item_t;

  // Arctangent of 2^-i in units of 2^-20 turn.
  function automatic logic [ACC_W-1:0] atan_entry(input logic [STAGE_W-1:0] i);
    logic [ACC_W-1:0] v;
    case (i)
      5'd0:  v = 20'd131072;
      5'd1:  v = 20'd77376;
      5'd2:  v = 20'd40884;
      5'd3:  v = 20'd20753;
      5'd4:  v = 20'd10417;
      5'd5:  v = 20'd5213;
      5'd6:  v = 20'd2607;
      5'd7:  v = 20'd1304;
      5'd8:  v = 20'd652;
      5'd9:  v = 20'd326;
      5'd10: v = 20'd163;
      5'd11: v = 20'd81;
      5'd12: v = 20'd41;
      5'd13: v = 20'd20;
      5'd14: v = 20'd10;
      5'd15: v = 20'd5;
      5'd16: v = 20'd3;
      5'd17: v = 20'd1;
      5'd18: v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/brsm_prep.sv -----
// Input stage: coordinate differences, squares and pre-rotation into the right half plane.
`default_nettype none

module brsm_prep import brsm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire logic [2:0]         beacon_index,
  input  wire logic               beacon_active,
  input  wire logic [COORD_W-1:0] beacon_x,
  input  wire logic [COORD_W-1:0] beacon_z,
  input  wire logic [COORD_W-1:0] robot_x,
  input  wire logic [COORD_W-1:0] robot_z,
  input  wire logic [15:0]        robot_heading,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output brsm_item_t              dn_item
);

  logic                     valid_r, valid_nxt;
  brsm_item_t               item_r, item_nxt;
  logic signed [DIFF_W-1:0] dx, dz;
  logic signed [XY_W-1:0]   xs, ys;
  logic signed [2*DIFF_W-1:0] px, pz;

  // Differences are exact in 15 bits; squares fit 28 bits unsigned.
  always_comb begin
    dx = $signed({beacon_x[COORD_W-1], beacon_x}) - $signed({robot_x[COORD_W-1], robot_x});
    dz = $signed({beacon_z[COORD_W-1], beacon_z}) - $signed({robot_z[COORD_W-1], robot_z});
    px = dx * dx;
    pz = dz * dz;
    xs = $signed({{(XY_W-DIFF_W-8){dz[DIFF_W-1]}}, dz, 8'd0});
    ys = $signed({{(XY_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'd0});

    item_nxt.idx     = beacon_index;
    item_nxt.active  = beacon_active && (int'(beacon_index) < BEACON_COUNT);
    item_nxt.zero    = (dx == '0) && (dz == '0);
    item_nxt.heading = robot_heading;
    item_nxt.sqx     = px[SQ_W-1:0];
    item_nxt.sqz     = pz[SQ_W-1:0];
    // A negative forward difference is turned by a half turn first.
    if (dz[DIFF_W-1]) begin
      item_nxt.x   = -xs;
      item_nxt.y   = -ys;
      item_nxt.acc = HALF_TURN;
    end else begin
      item_nxt.x   = xs;
      item_nxt.y   = ys;
      item_nxt.acc = '0;
    end
  end

  // Stage handshake: load when empty or when the next cell takes the current request.
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

`default_nettype wire

// ----- rtl/brsm_cell.sv -----
// One rotation cell of the vectoring arctangent chain.
`default_nettype none

module brsm_cell import brsm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [STAGE_W-1:0] stage_idx,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire brsm_item_t         up_item,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output brsm_item_t              dn_item
);

  logic                   valid_r, valid_nxt;
  brsm_item_t             item_r, item_nxt;
  logic signed [XY_W-1:0] x_in, y_in, x_sh, y_sh;
  logic [ACC_W-1:0]       angle;

  // Rotate toward the x axis and accumulate the angle turned.
  always_comb begin
    x_in  = up_item.x;
    y_in  = up_item.y;
    x_sh  = x_in >>> stage_idx;
    y_sh  = y_in >>> stage_idx;
    angle = atan_entry(stage_idx);
    item_nxt = up_item;
    if (y_in[XY_W-1]) begin
      item_nxt.x   = x_in - y_sh;
      item_nxt.y   = y_in + x_sh;
      item_nxt.acc = up_item.acc - angle;
    end else begin
      item_nxt.x   = x_in + y_sh;
      item_nxt.y   = y_in - x_sh;
      item_nxt.acc = up_item.acc + angle;
    end
  end

  // Cell handshake: a bubble ahead lets the cell load even when the output stalls.
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

`default_nettype wire

// ----- rtl/brsm_post.sv -----
// Output stage: bearing rounding, heading and offset, range rings and the receiver mask.
`default_nettype none
`include "assert_macros.svh"

module brsm_post import brsm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     bearing_offset,
  input  wire logic [SQ_W-1:0] rsq_wide,
  input  wire logic [SQ_W-1:0] rsq_mid,
  input  wire logic [SQ_W-1:0] rsq_near,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire brsm_item_t      up_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           out_echo,
  output logic [15:0]          out_mask,
  output logic [3:0]           out_centre
);

  logic          valid_r, valid_nxt;
  logic [2:0]    echo_r, echo_nxt;
  logic [15:0]   mask_r, mask_nxt;
  logic [3:0]    centre_r, centre_nxt;
  logic [ACC_W:0]  acc_rnd;
  logic [15:0]   bearing_raw, bearing;
  logic [3:0]    centre;
  logic [SQ_W:0] dist_sq;
  logic          ring_wide, ring_mid, ring_near;

  // Round the angle to 16 bits, then turn it into the receiver frame.
  always_comb begin
    acc_rnd     = {1'b0, up_item.acc} + (ACC_W+1)'(8);
    bearing_raw = up_item.zero ? 16'd0 : acc_rnd[ACC_W-1:ACC_W-16];
    bearing     = bearing_raw - up_item.heading + bearing_offset;
    centre      = bearing[15:12];
    dist_sq     = {1'b0, up_item.sqx} + {1'b0, up_item.sqz};
    ring_wide   = dist_sq < {1'b0, rsq_wide};
    ring_mid    = dist_sq < {1'b0, rsq_mid};
    ring_near   = dist_sq < {1'b0, rsq_near};
  end

  // Light the centre receiver and its neighbors around the ring.
  always_comb begin
    echo_nxt   = up_item.idx;
    mask_nxt   = 16'd1 << centre;
    centre_nxt = centre;
    if (ring_wide) begin
      mask_nxt = mask_nxt | (16'd1 << (centre + 4'd1)) | (16'd1 << (centre - 4'd1));
    end
    if (ring_mid) begin
      mask_nxt = mask_nxt | (16'd1 << (centre + 4'd2)) | (16'd1 << (centre - 4'd2));
    end
    if (ring_near) begin
      mask_nxt = mask_nxt | (16'd1 << (centre + 4'd3)) | (16'd1 << (centre - 4'd3));
    end
    if (!up_item.active) begin
      mask_nxt   = 16'd0;
      centre_nxt = 4'd0;
    end
  end

  // Output register: takes a new request whenever it is empty or being drained.
  assign up_ready  = !valid_r || out_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      echo_r   <= echo_nxt;
      mask_r   <= mask_nxt;
      centre_r <= centre_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_echo   = echo_r;
  assign out_mask   = mask_r;
  assign out_centre = centre_r;

  // A lit mask always contains its centre receiver; an empty one reports receiver zero.
  `BRSM_ASSERT_IMP(a_centre_lit, valid_r, ((mask_r == 16'd0) && (centre_r == 4'd0)) || mask_r[centre_r], "centre receiver not in mask")
  // Rings are symmetric, so the lit count is zero or odd and at most seven.
  `BRSM_ASSERT_IMP(a_mask_count, valid_r, ($countones(mask_r) == 0) || ($countones(mask_r) == 1) || ($countones(mask_r) == 3) || ($countones(mask_r) == 5) || ($countones(mask_r) == 7), "receiver mask has a bad count")
  // A loaded request always shows up at the output in the next cycle.
  `BRSM_ASSERT_NEXT(a_load_shows, up_valid && up_ready, valid_r, "loaded request missing at output")
  // An absent beacon yields an empty mask.
  `BRSM_ASSERT_NEXT(a_inactive_empty, up_valid && up_ready && !up_item.active, mask_r == 16'd0, "inactive beacon lit receivers")

endmodule

`default_nettype wire

// ----- rtl/beacon_receiver_sector_mask_top.sv -----
// Top level of the beacon receiver sector mask: configuration registers and the cell chain.
//
// Usage. Each request on the in_ stream is one query: beacon and robot positions in
// millimetres, the robot heading as a 16-bit binary angle, the beacon index and an
// active flag. Each request gives exactly one result on the out_ stream: the echoed
// index, the 16-bit receiver mask and the centre receiver.
// The pipeline holds one input stage, one cell per arctangent rotation (16 rotation
// cells), and one output register. One request is taken every cycle while the output
// is drained or the chain still has an empty slot.
// The configuration port writes the offset or one of the three radii, chosen by cfg_index;
// a radius is squared as it is written. Write it only while no request is in flight.
// Reset (synchronous, rst_n low) empties every stage and loads the default offset of
// 80 degrees and radii of 1.5 m, 1 m and 0.5 m. When the receiver holds out_tready low,
// the result stays in the output register and the stages behind it keep filling any
// empty slots, so in_tready drops only once the whole chain is full.
`default_nettype none

module beacon_receiver_sector_mask_top import brsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: beacon_x[13:0], beacon_z[27:14], robot_x[41:28], robot_z[55:42],
  // robot_heading[71:56]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,
  // in_tuser: beacon_index[2:0], beacon_active[3]
  input  wire logic [3:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: receiver_mask[15:0], centre_receiver[19:16], zero fill[23:20]
  output logic [23:0]      out_tdata,
  // out_tuser: beacon_echo[2:0]
  output logic [2:0]       out_tuser,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0]     offset_r, offset_nxt;
  logic [SQ_W-1:0] rsq_wide_r, rsq_wide_nxt;
  logic [SQ_W-1:0] rsq_mid_r, rsq_mid_nxt;
  logic [SQ_W-1:0] rsq_near_r, rsq_near_nxt;
  logic [SQ_W-1:0] wr_sq;

  logic [CELL_COUNT:0] chain_valid;
  logic [CELL_COUNT:0] chain_ready;
  brsm_item_t          chain_item [CELL_COUNT+1];

  logic [15:0] res_mask;
  logic [3:0]  res_centre;

  // Configuration writes; radii are kept squared for the distance compare.
  always_comb begin
    wr_sq        = SQ_W'(cfg_wdata[13:0] * cfg_wdata[13:0]);
    offset_nxt   = offset_r;
    rsq_wide_nxt = rsq_wide_r;
    rsq_mid_nxt  = rsq_mid_r;
    rsq_near_nxt = rsq_near_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BEARING_OFFSET: offset_nxt   = cfg_wdata;
        CFG_RADIUS_WIDE:    rsq_wide_nxt = wr_sq;
        CFG_RADIUS_MID:     rsq_mid_nxt  = wr_sq;
        CFG_RADIUS_NEAR:    rsq_near_nxt = wr_sq;
        default:            offset_nxt   = offset_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= BEARING_OFFSET_RST;
      rsq_wide_r <= RSQ_WIDE_RST;
      rsq_mid_r  <= RSQ_MID_RST;
      rsq_near_r <= RSQ_NEAR_RST;
    end else begin
      offset_r   <= offset_nxt;
      rsq_wide_r <= rsq_wide_nxt;
      rsq_mid_r  <= rsq_mid_nxt;
      rsq_near_r <= rsq_near_nxt;
    end
  end

  // Input stage.
  brsm_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (in_tvalid),
    .up_ready      (in_tready),
    .beacon_index  (in_tuser[2:0]),
    .beacon_active (in_tuser[3]),
    .beacon_x      (in_tdata[13:0]),
    .beacon_z      (in_tdata[27:14]),
    .robot_x       (in_tdata[41:28]),
    .robot_z       (in_tdata[55:42]),
    .robot_heading (in_tdata[71:56]),
    .dn_valid      (chain_valid[0]),
    .dn_ready      (chain_ready[0]),
    .dn_item       (chain_item[0])
  );

  // Chain of rotation cells, one per arctangent step.
  for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
    brsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (STAGE_W'(g)),
      .up_valid  (chain_valid[g]),
      .up_ready  (chain_ready[g]),
      .up_item   (chain_item[g]),
      .dn_valid  (chain_valid[g+1]),
      .dn_ready  (chain_ready[g+1]),
      .dn_item   (chain_item[g+1])
    );
  end

  // Output stage.
  brsm_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .bearing_offset (offset_r),
    .rsq_wide       (rsq_wide_r),
    .rsq_mid        (rsq_mid_r),
    .rsq_near       (rsq_near_r),
    .up_valid       (chain_valid[CELL_COUNT]),
    .up_ready       (chain_ready[CELL_COUNT]),
    .up_item        (chain_item[CELL_COUNT]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_echo       (out_tuser),
    .out_mask       (res_mask),
    .out_centre     (res_centre)
  );

  assign out_tdata = {4'd0, res_centre, res_mask};

endmodule

`default_nettype wire
